// ----- design/mul_div_64_unit_assert.svh -----
// Assertion macros for the multiply-divide unit.
// Used by the top level; the including module must provide clk and rst.
`ifndef MUL_DIV_64_UNIT_ASSERT_SVH
`define MUL_DIV_64_UNIT_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define MD64_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mul_div_64_unit: same-cycle check failed");

// Implication after a fixed number of cycles, checked outside reset.
`define MD64_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("mul_div_64_unit: delayed check failed");

`endif

// ----- design/md64_pkg.sv -----
// Shared widths, constants and stage types for the multiply-divide unit.
// No dependencies; used by every module of the block.
package md64_pkg;

  localparam int MDW    = 64;
  localparam int HALF_W = MDW / 2;

  localparam logic [MDW-1:0] ALL_ONES = {MDW{1'b1}};

  // Number of division cells: one quotient bit per cell.
  localparam int DIV_CELLS = MDW;

  // Product as handed from the multiplier to the divider front end.
  typedef struct packed {
    logic           valid;
    logic [MDW-1:0] hi;
    logic [MDW-1:0] lo;
    logic [MDW-1:0] dvs;
  } md64_prod_t;

  // Data carried from one division cell to the next.
  typedef struct packed {
    logic           valid;
    logic           ovf;
    logic           dbz;
    logic [MDW-1:0] rem;
    logic [MDW-1:0] low;
    logic [MDW-1:0] quo;
    logic [MDW-1:0] dvs;
  } md64_stage_t;

endpackage

// ----- design/md64_mul.sv -----
// Two-stage 64 x 64 -> 128 bit unsigned multiplier built from 32-bit partials.
// Depends on md64_pkg.
module md64_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [md64_pkg::MDW-1:0]   a,
  input  logic [md64_pkg::MDW-1:0]   b,
  input  logic [md64_pkg::MDW-1:0]   d,
  output md64_pkg::md64_prod_t       prod
);

  localparam int W = md64_pkg::MDW;
  localparam int H = md64_pkg::HALF_W;

  logic         valid_p;
  logic [W-1:0] p0, p1, p2, p3;
  logic [W-1:0] dvs_p;
  logic [2*W-1:0] sum;

  // First stage: four independent 32 x 32 partial products.
  always_ff @(posedge clk) begin
    p0    <= W'(a[H-1:0]) * W'(b[H-1:0]);
    p1    <= W'(a[H-1:0]) * W'(b[W-1:H]);
    p2    <= W'(a[W-1:H]) * W'(b[H-1:0]);
    p3    <= W'(a[W-1:H]) * W'(b[W-1:H]);
    dvs_p <= d;
    if (rst) begin
      valid_p <= 1'b0;
    end else begin
      valid_p <= in_valid;
    end
  end

  // Second stage: weighted sum of the partials.
  assign sum = {p3, p0} + {{H{1'b0}}, p1, {H{1'b0}}} + {{H{1'b0}}, p2, {H{1'b0}}};

  always_ff @(posedge clk) begin
    prod.hi  <= sum[2*W-1:W];
    prod.lo  <= sum[W-1:0];
    prod.dvs <= dvs_p;
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= valid_p;
    end
  end

endmodule

// ----- design/md64_div_cell.sv -----
// One restoring-division cell: produces a single quotient bit per transaction.
// Depends on md64_pkg.
module md64_div_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  md64_pkg::md64_stage_t din,
  output md64_pkg::md64_stage_t dout
);

  localparam int W = md64_pkg::MDW;

  logic [W-1:0] rem_sh;
  logic [W:0]   diff;
  logic         take;

  // A set top bit means the shifted remainder exceeds the divisor, so the
  // 65-bit difference is then never negative.
  assign rem_sh = {din.rem[W-2:0], din.low[W-1]};
  assign diff   = {din.rem[W-1], rem_sh} - {1'b0, din.dvs};
  assign take   = ~diff[W];

  always_ff @(posedge clk) begin
    dout.ovf <= din.ovf;
    dout.dbz <= din.dbz;
    dout.rem <= take ? diff[W-1:0] : rem_sh;
    dout.low <= {din.low[W-2:0], 1'b0};
    dout.quo <= {din.quo[W-2:0], take};
    dout.dvs <= din.dvs;
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

endmodule

// ----- design/mul_div_64_unit.sv -----
// Top level of the 64-bit multiply-divide unit.
// Depends on md64_pkg, md64_mul, md64_div_cell and mul_div_64_unit_assert.svh.
//
// Usage. A transaction is offered by raising start with operand, factor and
// divisor on their ports; it is taken at a rising edge where start is high
// and busy is low. The unit is fully pipelined, so busy is low whenever the
// unit is out of reset and a new transaction may be offered in every cycle.
//
// Each transaction returns one result: quotient, overflow and divide_by_zero,
// valid for exactly one cycle while done is high. The result is the floor of
// operand * factor / divisor. A zero divisor returns all ones with
// divide_by_zero set; a quotient wider than 64 bits returns all ones with
// overflow set.
//
// A result passes through the two multiplier stages, one flag stage, the chain
// of 64 division cells (one quotient bit each) and the output register.
// Throughput is one transaction per cycle.
//
// Reset is synchronous; it empties the pipeline, and busy is high while rst
// is held so that nothing is taken and then lost. The receiver cannot stall:
// results are presented once and must be captured in that cycle.
`include "mul_div_64_unit_assert.svh"

module mul_div_64_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [md64_pkg::MDW-1:0] operand,
  input  logic [md64_pkg::MDW-1:0] factor,
  input  logic [md64_pkg::MDW-1:0] divisor,
  output logic                     done,
  output logic [md64_pkg::MDW-1:0] quotient,
  output logic                     overflow,
  output logic                     divide_by_zero
);

  localparam int W       = md64_pkg::MDW;
  localparam int N       = md64_pkg::DIV_CELLS;
  // Edges from the accepting edge to the edge at which the result is taken.
  localparam int LATENCY = N + 4;

  md64_pkg::md64_prod_t  prod;
  md64_pkg::md64_stage_t head;
  md64_pkg::md64_stage_t chain [0:N];
  logic                  accept;

  // The pipeline never fills up, so only reset holds transactions off.
  assign busy   = rst;
  assign accept = start & ~busy;

  md64_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .a        (operand),
    .b        (factor),
    .d        (divisor),
    .prod     (prod)
  );

  // Flag stage. The divider needs hi below the divisor; when that fails the
  // quotient cannot fit, and a zero divisor is reported on its own.
  always_ff @(posedge clk) begin
    head.dbz <= (prod.dvs == '0);
    head.ovf <= (prod.dvs != '0) && (prod.hi >= prod.dvs);
    head.rem <= prod.hi;
    head.low <= prod.lo;
    head.quo <= '0;
    head.dvs <= prod.dvs;
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= prod.valid;
    end
  end

  assign chain[0] = head;

  // The division chain: each cell shifts in one dividend bit and emits one
  // quotient bit, handing its remainder to the next cell.
  for (genvar i = 0; i < N; i++) begin : g_cell
    md64_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Output register. Flagged transactions carry a meaningless quotient
  // through the chain, so it is replaced by all ones here.
  always_ff @(posedge clk) begin
    quotient       <= (chain[N].ovf || chain[N].dbz) ? md64_pkg::ALL_ONES : chain[N].quo;
    overflow       <= chain[N].ovf;
    divide_by_zero <= chain[N].dbz;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[N].valid;
    end
  end

  `MD64_ASSERT_SAME(a_flags_exclusive, done, !(overflow && divide_by_zero))
  `MD64_ASSERT_SAME(a_dbz_saturates, done && divide_by_zero, quotient == md64_pkg::ALL_ONES)
  `MD64_ASSERT_SAME(a_ovf_saturates, done && overflow, quotient == md64_pkg::ALL_ONES)
  `MD64_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)

endmodule
